@@ hdl/olvd_pkg.sv @@
// Package for the ordered list block: sizes, request and status codes,
// cell command codes and the command struct shared by the top level and cells.
`timescale 1ns / 1ps

package olvd_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int WAVE_W   = $clog2(CAPACITY);

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // cell commands
    localparam logic [2:0] C_NOP        = 3'd0;
    localparam logic [2:0] C_PUSH_FRONT = 3'd1;
    localparam logic [2:0] C_PUSH_BACK  = 3'd2;
    localparam logic [2:0] C_POP_FRONT  = 3'd3;
    localparam logic [2:0] C_POP_BACK   = 3'd4;
    localparam logic [2:0] C_MATCH      = 3'd5;
    localparam logic [2:0] C_WAVE       = 3'd6;
    localparam logic [2:0] C_REMOVE     = 3'd7;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] key;
    } t_cell_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       entry_count;
    } t_result;

endpackage

@@ hdl/olvd_cell.sv @@
// One slot of the list: a word, its used bit and the first-match search bits.
// Depends on olvd_pkg for the command struct and codes.
`timescale 1ns / 1ps

module olvd_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  olvd_pkg::t_cell_cmd               i_cmd,
    input  logic signed [olvd_pkg::DATA_W-1:0] i_left_value,
    input  logic                              i_left_used,
    input  logic                              i_left_mark,
    input  logic signed [olvd_pkg::DATA_W-1:0] i_right_value,
    input  logic                              i_right_used,
    output logic signed [olvd_pkg::DATA_W-1:0] o_value,
    output logic                              o_used,
    output logic                              o_mark
);

    logic signed [olvd_pkg::DATA_W-1:0] r_value, n_value;
    logic                               r_used, n_used;
    logic                               r_hit, n_hit;
    logic                               r_pre, n_pre;

    always_comb begin
        n_value = r_value;
        n_used  = r_used;
        n_hit   = r_hit;
        n_pre   = r_pre;
        case (i_cmd.op)
            olvd_pkg::C_PUSH_FRONT: begin
                n_value = i_left_value;
                n_used  = i_left_used;
            end
            olvd_pkg::C_PUSH_BACK: begin
                // first free slot takes the word
                if (!r_used && i_left_used) begin
                    n_value = i_cmd.key;
                    n_used  = 1'b1;
                end
            end
            olvd_pkg::C_POP_FRONT: begin
                n_value = i_right_value;
                n_used  = i_right_used;
            end
            olvd_pkg::C_POP_BACK: begin
                n_used = i_right_used;
            end
            olvd_pkg::C_MATCH: begin
                n_hit = r_used && (r_value == i_cmd.key);
                n_pre = 1'b0;
            end
            olvd_pkg::C_WAVE: begin
                // advance the "match seen earlier" flag one slot per cycle
                n_pre = i_left_mark;
            end
            olvd_pkg::C_REMOVE: begin
                if (r_pre || r_hit) begin
                    n_value = i_right_value;
                    n_used  = i_right_used;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_hit   <= n_hit;
        r_pre   <= n_pre;
    end

    assign o_value = r_value;
    assign o_used  = r_used;
    assign o_mark  = r_pre || r_hit;

endmodule

@@ hdl/ordered_list_with_value_delete.sv @@
// Top level of the ordered list: request control, the row of list cells,
// and the result register with a skid stage. Depends on olvd_pkg, olvd_cell.
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit words, CAPACITY slots in a row of
// cells that shift toward the front or the back as words come and go.
// Input channel: i_in_valid / o_in_ready with i_kind and i_item_value.
// Output channel: o_out_valid / i_out_ready with o_removed_value, o_status
// and o_entry_count; every request yields exactly one result item.
// Push and pop results go to the result register, or to the skid stage
// while that register is busy; a new item can be taken every cycle while
// the skid stage is empty and no delete is in progress.
// A delete runs in steps: the key is taken, every slot is compared against
// it, the first-match flag travels down the row of cells, and the gap is
// closed.
// The result register and a one-entry skid stage let an item be accepted
// while a result waits; when both are full the input stalls until the
// receiver takes a result. Results are never dropped.
// Reset (synchronous, active low) empties the list and both result stages;
// no clearing pass is needed and the block is ready in the next cycle.
module ordered_list_with_value_delete (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [olvd_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [olvd_pkg::DATA_W-1:0]   i_item_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [olvd_pkg::DATA_W-1:0]   o_removed_value,
    output logic [olvd_pkg::STATUS_W-1:0]        o_status,
    output logic [olvd_pkg::COUNT_W-1:0]         o_entry_count
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_WAVE  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [olvd_pkg::CNT_W-1:0]          r_count, n_count;
    logic [olvd_pkg::WAVE_W-1:0]         r_wave, n_wave;
    logic signed [olvd_pkg::DATA_W-1:0]  r_key;
    olvd_pkg::t_result                   r_out, r_skid, w_res;
    logic                                r_out_valid, r_skid_valid;
    logic                                w_res_fire, w_accept, w_out_free;
    olvd_pkg::t_cell_cmd                 w_cmd;

    logic signed [olvd_pkg::DATA_W-1:0]  w_value [olvd_pkg::CAPACITY];
    logic [olvd_pkg::CAPACITY-1:0]       w_used;
    logic [olvd_pkg::CAPACITY-1:0]       w_mark;

    logic                                w_full, w_empty;
    logic [olvd_pkg::CNT_W-1:0]          w_last_cnt;
    logic [olvd_pkg::IDX_W-1:0]          w_last_idx;
    logic [olvd_pkg::CNT_W+olvd_pkg::COUNT_W-1:0] w_count_ext;

    assign w_full     = (r_count == olvd_pkg::CNT_W'(olvd_pkg::CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_last_cnt = r_count - olvd_pkg::CNT_W'(1);
    assign w_last_idx = w_last_cnt[olvd_pkg::IDX_W-1:0];
    assign w_count_ext = {{olvd_pkg::COUNT_W{1'b0}}, n_count};

    assign o_in_ready = (r_state == S_IDLE) && !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;

    // cell row
    genvar g;
    generate
        for (g = 0; g < olvd_pkg::CAPACITY; g++) begin : g_cell
            logic signed [olvd_pkg::DATA_W-1:0] w_lv, w_rv;
            logic                               w_lu, w_lm, w_ru;
            if (g == 0) begin : g_front
                assign w_lv = w_cmd.key;
                assign w_lu = 1'b1;
                assign w_lm = 1'b0;
            end else begin : g_mid_l
                assign w_lv = w_value[g-1];
                assign w_lu = w_used[g-1];
                assign w_lm = w_mark[g-1];
            end
            if (g == olvd_pkg::CAPACITY - 1) begin : g_back
                assign w_rv = '0;
                assign w_ru = 1'b0;
            end else begin : g_mid_r
                assign w_rv = w_value[g+1];
                assign w_ru = w_used[g+1];
            end
            olvd_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (w_cmd),
                .i_left_value  (w_lv),
                .i_left_used   (w_lu),
                .i_left_mark   (w_lm),
                .i_right_value (w_rv),
                .i_right_used  (w_ru),
                .o_value       (w_value[g]),
                .o_used        (w_used[g]),
                .o_mark        (w_mark[g])
            );
        end
    endgenerate

    // request control
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_wave     = r_wave;
        w_cmd.op   = olvd_pkg::C_NOP;
        w_cmd.key  = (r_state == S_IDLE) ? i_item_value : r_key;
        w_res_fire = 1'b0;
        w_res.removed_value = '0;
        w_res.status        = olvd_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_res_fire = 1'b1;
                    case (i_kind)
                        olvd_pkg::KIND_PUSH_FRONT: begin
                            if (w_full) begin
                                w_res.status = olvd_pkg::ST_FULL;
                            end else begin
                                w_cmd.op = olvd_pkg::C_PUSH_FRONT;
                                n_count  = r_count + olvd_pkg::CNT_W'(1);
                            end
                        end
                        olvd_pkg::KIND_PUSH_BACK: begin
                            if (w_full) begin
                                w_res.status = olvd_pkg::ST_FULL;
                            end else begin
                                w_cmd.op = olvd_pkg::C_PUSH_BACK;
                                n_count  = r_count + olvd_pkg::CNT_W'(1);
                            end
                        end
                        olvd_pkg::KIND_POP_FRONT: begin
                            if (w_empty) begin
                                w_res.status = olvd_pkg::ST_MISS;
                            end else begin
                                w_cmd.op            = olvd_pkg::C_POP_FRONT;
                                w_res.removed_value = w_value[0];
                                n_count             = w_last_cnt;
                            end
                        end
                        olvd_pkg::KIND_POP_BACK: begin
                            if (w_empty) begin
                                w_res.status = olvd_pkg::ST_MISS;
                            end else begin
                                w_cmd.op            = olvd_pkg::C_POP_BACK;
                                w_res.removed_value = w_value[w_last_idx];
                                n_count             = w_last_cnt;
                            end
                        end
                        olvd_pkg::KIND_DELETE: begin
                            // result comes after the search
                            w_res_fire = 1'b0;
                            n_state    = S_MATCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MATCH: begin
                w_cmd.op = olvd_pkg::C_MATCH;
                n_wave   = '0;
                n_state  = S_WAVE;
            end
            S_WAVE: begin
                w_cmd.op = olvd_pkg::C_WAVE;
                n_wave   = r_wave + olvd_pkg::WAVE_W'(1);
                if (r_wave == olvd_pkg::WAVE_W'(olvd_pkg::CAPACITY - 2)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                w_res_fire = 1'b1;
                n_state    = S_IDLE;
                if (w_mark[olvd_pkg::CAPACITY-1]) begin
                    // the removed word equals the key
                    w_cmd.op            = olvd_pkg::C_REMOVE;
                    w_res.removed_value = r_key;
                    n_count             = w_last_cnt;
                end else begin
                    w_res.status = olvd_pkg::ST_MISS;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_res.entry_count = w_count_ext[olvd_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wave  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wave  <= n_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_item_value;
        end
    end

    // result register and skid stage
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out       <= r_skid;
                r_out_valid <= 1'b1;
                if (w_res_fire) begin
                    r_skid       <= w_res;
                    r_skid_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_res_fire) begin
                r_out       <= w_res;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (w_res_fire) begin
            // hold the waiting item, park the new one
            r_skid       <= w_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_out.removed_value;
    assign o_status        = r_out.status;
    assign o_entry_count   = r_out.entry_count;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while the output register is empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= olvd_pkg::CNT_W'(olvd_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_front_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used[0] == (r_count != '0))
        else $error("front cell used bit disagrees with entry count");

    a_back_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used[olvd_pkg::CAPACITY-1] == w_full)
        else $error("back cell used bit disagrees with full flag");

    a_delete_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == olvd_pkg::KIND_DELETE) |=> (r_state == S_MATCH))
        else $error("delete request did not start the search");
`endif

endmodule
